// ----- sv/front_middle_back_queue_defines.svh -----
// Assertion macros shared by the front-middle-back queue RTL.
`ifndef FRONT_MIDDLE_BACK_QUEUE_DEFINES_SVH
`define FRONT_MIDDLE_BACK_QUEUE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define FMBQ_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define FMBQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/fmbq_pkg.sv -----
// Shared types and constants for the front-middle-back queue.
package fmbq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed widths of the transaction fields
  localparam int OP_W = 3;
  localparam int IO_W = 32;
  localparam int ST_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT  = 3'd0,
    OP_PUSH_MIDDLE = 3'd1,
    OP_PUSH_BACK   = 3'd2,
    OP_POP_FRONT   = 3'd3,
    OP_POP_MIDDLE  = 3'd4,
    OP_POP_BACK    = 3'd5
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// ----- sv/front_middle_back_queue.sv -----
// Front-middle-back queue: ordered store with push/pop at front, middle and back.
//
// Usage:
//   Input: present in_operation and in_push_value with start high while busy
//   is low; the transaction is taken at that clock edge. Codes: push front,
//   push middle, push back, pop front, pop middle, pop back; others do nothing.
//   Output: every transaction yields one result on out_pop_value, out_status
//   and out_occupancy, held for exactly one cycle with out_valid high. The
//   receiver has no back pressure; results are never held off.
//   Pop on empty, push on full and unused codes finish without raising busy;
//   every other transaction holds busy high until its result is shown.
//   Entries live in a circular buffer in one RAM with registered read. Front
//   and back operations move the head or tail pointer only; middle operations
//   slide the back half one entry per cycle through the single read port, and
//   that sliding sets the rate. A new transaction may start in the cycle its
//   predecessor's result is shown.
//   Reset (rst_n low, synchronous) empties the queue; RAM contents are left.
module front_middle_back_queue #(
  parameter int DEPTH      = fmbq_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = fmbq_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [fmbq_pkg::OP_W-1:0]         in_operation,
  input  logic signed [fmbq_pkg::IO_W-1:0]  in_push_value,
  output logic                              out_valid,
  output logic signed [fmbq_pkg::IO_W-1:0]  out_pop_value,
  output logic [fmbq_pkg::ST_W-1:0]         out_status,
  output logic [$clog2(DEPTH+1)-1:0]        out_occupancy
);

  import fmbq_pkg::*;

  `include "front_middle_back_queue_defines.svh"

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_PUSH = 3'b010,
    S_POP  = 3'b100
  } state_t;

  // Control state
  state_t          state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            more_r, more_nxt;
  logic            pend_r, pend_nxt;
  logic            first_r, first_nxt;
  logic            front_r, front_nxt;
  logic            out_valid_r, out_valid_nxt;

  // Operation context
  logic [AW-1:0]         src_r, src_nxt;
  logic [AW-1:0]         last_r, last_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic [AW-1:0]         pend_src_r, pend_src_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic [DATA_WIDTH-1:0] pop_data_r, pop_data_nxt;

  // Result registers
  logic [IO_W-1:0] out_pop_value_r, out_pop_value_nxt;
  status_t         out_status_r, out_status_nxt;
  logic [CW-1:0]   out_occupancy_r, out_occupancy_nxt;

  // RAM port
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // Helpers
  logic                       accept;
  logic                       full;
  logic                       empty;
  logic [AW-1:0]              n_aw;
  logic [CW-1:0]              n_m1;
  logic [AW-1:0]              head_dec;
  logic [AW-1:0]              head_inc;
  logic [DATA_WIDTH+IO_W-1:0] in_wide;
  logic [DATA_WIDTH+IO_W-1:0] pop_wide;

  // Map a logical position to a RAM address around the circular head
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] h, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, l};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign n_aw     = count_r[AW-1:0];
  assign n_m1     = count_r - CW'(1);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);

  // Width adaptation between the 32-bit ports and the stored word
  assign in_wide  = {{DATA_WIDTH{1'b0}}, in_push_value};
  assign pop_wide = {{IO_W{1'b0}}, pop_data_r};

  // Next-state and RAM control
  always_comb begin
    state_nxt         = state_r;
    head_nxt          = head_r;
    count_nxt         = count_r;
    more_nxt          = more_r;
    pend_nxt          = pend_r;
    first_nxt         = first_r;
    front_nxt         = front_r;
    src_nxt           = src_r;
    last_nxt          = last_r;
    pos_nxt           = pos_r;
    pend_src_nxt      = pend_src_r;
    val_nxt           = val_r;
    pop_data_nxt      = pop_data_r;
    out_valid_nxt     = 1'b0;
    out_pop_value_nxt = out_pop_value_r;
    out_status_nxt    = out_status_r;
    out_occupancy_nxt = out_occupancy_r;
    ram_we            = 1'b0;
    ram_waddr         = '0;
    ram_wdata         = ram_rdata;
    ram_re            = 1'b0;
    ram_raddr         = to_phys(head_r, src_r);

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            OP_PUSH_FRONT, OP_PUSH_MIDDLE, OP_PUSH_BACK: begin
              if (full) begin
                // Drop the value, report full
                out_valid_nxt     = 1'b1;
                out_pop_value_nxt = '0;
                out_status_nxt    = ST_FULL;
                out_occupancy_nxt = count_r;
              end else begin
                state_nxt = S_PUSH;
                val_nxt   = in_wide[DATA_WIDTH-1:0];
                src_nxt   = n_m1[AW-1:0];
                pend_nxt  = 1'b0;
                more_nxt  = 1'b0;
                if (in_operation == OP_PUSH_FRONT) begin
                  head_nxt = head_dec;
                  pos_nxt  = '0;
                end else if (in_operation == OP_PUSH_MIDDLE) begin
                  pos_nxt  = n_aw >> 1;
                  more_nxt = !empty;
                end else begin
                  pos_nxt = n_aw;
                end
              end
            end
            OP_POP_FRONT, OP_POP_MIDDLE, OP_POP_BACK: begin
              if (empty) begin
                // Nothing to remove, report empty
                out_valid_nxt     = 1'b1;
                out_pop_value_nxt = '1;
                out_status_nxt    = ST_EMPTY;
                out_occupancy_nxt = count_r;
              end else begin
                state_nxt = S_POP;
                more_nxt  = 1'b1;
                pend_nxt  = 1'b0;
                first_nxt = 1'b1;
                front_nxt = (in_operation == OP_POP_FRONT);
                last_nxt  = n_m1[AW-1:0];
                if (in_operation == OP_POP_FRONT) begin
                  src_nxt  = '0;
                  last_nxt = '0;
                end else if (in_operation == OP_POP_MIDDLE) begin
                  src_nxt = n_m1[AW-1:0] >> 1;
                end else begin
                  src_nxt = n_m1[AW-1:0];
                end
              end
            end
            default: begin
              // Unused code: report current state, change nothing
              out_valid_nxt     = 1'b1;
              out_pop_value_nxt = '0;
              out_status_nxt    = ST_OK;
              out_occupancy_nxt = count_r;
            end
          endcase
        end
      end

      S_PUSH: begin
        // Read entries from the tail down to the insert point
        if (more_r) begin
          ram_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_src_nxt = src_r;
          if (src_r == pos_r) begin
            more_nxt = 1'b0;
          end else begin
            src_nxt = src_r - AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
        end
        // Write each read entry one place toward the back
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = to_phys(head_r, pend_src_r + AW'(1));
          ram_wdata = ram_rdata;
        end else if (!more_r) begin
          // Gap is open: drop the new value in and finish
          ram_we            = 1'b1;
          ram_waddr         = to_phys(head_r, pos_r);
          ram_wdata         = val_r;
          count_nxt         = count_r + CW'(1);
          state_nxt         = S_IDLE;
          out_valid_nxt     = 1'b1;
          out_pop_value_nxt = '0;
          out_status_nxt    = ST_OK;
          out_occupancy_nxt = count_r + CW'(1);
        end
      end

      S_POP: begin
        // Read the removed entry, then the ones behind it
        if (more_r) begin
          ram_re       = 1'b1;
          pend_nxt     = 1'b1;
          pend_src_nxt = src_r;
          if (src_r == last_r) begin
            more_nxt = 1'b0;
          end else begin
            src_nxt = src_r + AW'(1);
          end
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (first_r) begin
            // Hold the removed value for the result
            pop_data_nxt = ram_rdata;
            first_nxt    = 1'b0;
          end else begin
            // Close the gap one place toward the front
            ram_we    = 1'b1;
            ram_waddr = to_phys(head_r, pend_src_r - AW'(1));
            ram_wdata = ram_rdata;
          end
        end else if (!more_r) begin
          count_nxt = count_r - CW'(1);
          if (front_r) begin
            head_nxt = head_inc;
          end
          state_nxt         = S_IDLE;
          out_valid_nxt     = 1'b1;
          out_pop_value_nxt = pop_wide[IO_W-1:0];
          out_status_nxt    = ST_OK;
          out_occupancy_nxt = count_r - CW'(1);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      more_r      <= 1'b0;
      pend_r      <= 1'b0;
      first_r     <= 1'b0;
      front_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      more_r      <= more_nxt;
      pend_r      <= pend_nxt;
      first_r     <= first_nxt;
      front_r     <= front_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    src_r           <= src_nxt;
    last_r          <= last_nxt;
    pos_r           <= pos_nxt;
    pend_src_r      <= pend_src_nxt;
    val_r           <= val_nxt;
    pop_data_r      <= pop_data_nxt;
    out_pop_value_r <= out_pop_value_nxt;
    out_status_r    <= out_status_nxt;
    out_occupancy_r <= out_occupancy_nxt;
  end

  fmbq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid     = out_valid_r;
  assign out_pop_value = out_pop_value_r;
  assign out_status    = out_status_r;
  assign out_occupancy = out_occupancy_r;

  // Checks
  `FMBQ_ASSERT_IMPL(a_count_bound, clk, rst_n, 1'b1, count_r <= CW'(DEPTH), "occupancy past depth")
  `FMBQ_ASSERT_IMPL(a_rw_distinct, clk, rst_n, ram_we && ram_re, ram_waddr != ram_raddr, "shift reads the entry it writes")
  `FMBQ_ASSERT_IMPL(a_we_busy, clk, rst_n, ram_we, state_r != S_IDLE, "RAM write while idle")
  `FMBQ_ASSERT_NEXT(a_pop_count, clk, rst_n, state_r == S_POP && !more_r && !pend_r, count_r == $past(count_r) - CW'(1), "pop did not reduce occupancy")

endmodule

// ----- sv/fmbq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fmbq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
